// ===== src/aml_named_package_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the named package extractor
// Each macro expects clk and rst to be visible in the calling module.
// ----------------------------------------------------------------------------
`ifndef AML_NAMED_PACKAGE_EXTRACTOR_MACROS_SVH
`define AML_NAMED_PACKAGE_EXTRACTOR_MACROS_SVH

// same-cycle implication, held off during reset
`define ANPE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ANPE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/anpe_pkg.sv =====
// ----------------------------------------------------------------------------
// anpe_pkg
// Types and constants of the AML named package extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package anpe_pkg;

  localparam int ELEM_VALUE_W = 64;
  localparam int ELEM_INDEX_W = 4;
  localparam int ELEM_COUNT_W = 5;
  localparam int OUT_TDATA_W  = 80;
  localparam int IN_TDATA_W   = 8;

  localparam logic [31:0] NAME_CODE_RESET = 32'h4649_425F;

  // AML opcodes
  localparam logic [7:0] OP_NAME    = 8'h08;
  localparam logic [7:0] OP_PACKAGE = 8'h12;
  localparam logic [7:0] OP_ZERO    = 8'h00;
  localparam logic [7:0] OP_ONE     = 8'h01;
  localparam logic [7:0] OP_BYTE    = 8'h0A;
  localparam logic [7:0] OP_WORD    = 8'h0B;
  localparam logic [7:0] OP_DWORD   = 8'h0C;
  localparam logic [7:0] OP_QWORD   = 8'h0E;

  typedef enum logic [2:0] {
    PH_SCAN  = 3'd0,
    PH_PKG0  = 3'd1,
    PH_PKGN  = 3'd2,
    PH_COUNT = 3'd3,
    PH_OP    = 3'd4,
    PH_DATA  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef struct packed {
    logic                    is_summary;
    logic [ELEM_VALUE_W-1:0] elem_value;
    logic [ELEM_INDEX_W-1:0] elem_index;
    logic [ELEM_COUNT_W-1:0] elem_count;
    logic                    found;
    logic                    run_end;
  } result_t;

endpackage

`default_nettype wire

// ===== src/aml_named_package_extractor.sv =====
// ----------------------------------------------------------------------------
// aml_named_package_extractor
// Finds a named AML package and streams out its integer elements.
// ----------------------------------------------------------------------------
// Takes one AML byte per cycle while the output queue has room. Each byte is
// decoded by one stage of combinational logic into the parser state and at
// most two results (an element and/or the end-of-scan summary), which go into
// a two-entry output queue. The input is ready whenever the queue will be
// empty after this cycle's output beat, so with the output side always ready
// a byte is taken every cycle; a byte that yields two results holds off the
// next byte while the second result drains. A byte's first result is shown
// in the cycle after it is taken. name_code may only be written while idle.
`default_nettype none

`include "aml_named_package_extractor_macros.svh"

module aml_named_package_extractor #(
  parameter int MAX_ELEMENTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // byte stream in
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  // results out
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [79:0] m_tdata,   // [63:0] elem_value, [67:64] elem_index,
                                      // [72:68] elem_count, [73] found, [79:74] zero
  output      logic        m_tuser,   // is_summary
  output      logic        m_tlast    // run_end
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = anpe_pkg::ELEM_INDEX_W;
  localparam int OCW   = anpe_pkg::ELEM_COUNT_W;

  // configuration
  logic [31:0] name_code;

  // parser state
  anpe_pkg::phase_t phase, phase_next;
  logic [39:0]       recent_bytes, recent_bytes_next;
  logic [1:0]        len_left, len_left_next;
  logic [CNT_W-1:0]  target_count, target_count_next;
  logic [CNT_W-1:0]  decoded_count, decoded_count_next;
  logic [3:0]        val_left, val_left_next;
  logic [2:0]        val_shift, val_shift_next;
  logic [63:0]       value_accum, value_accum_next;

  // per-byte decode
  logic [7:0]        b;
  logic              in_acc, out_acc;
  logic [39:0]       hdr;
  logic [63:0]       accum_or;
  logic [CNT_W-1:0]  clamp;
  logic [CNT_W-1:0]  dec_inc;
  logic [3:0]        val_left_dec;
  logic [1:0]        len_left_dec;
  logic              elem_emit;
  logic [63:0]       elem_val;
  logic              done_sum;
  logic              last_sum;
  logic              sum_any;

  anpe_pkg::result_t elem_res, sum_res, r0, r1;
  logic [1:0]        n_res;

  // output queue
  anpe_pkg::result_t q0, q1;
  logic [1:0]        q_count;

  assign b       = s_tdata;
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  assign hdr = {anpe_pkg::OP_NAME, name_code[7:0], name_code[15:8],
                name_code[23:16], name_code[31:24]};

  assign clamp = ({1'b0, b} > 9'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(b);
  assign dec_inc      = decoded_count + CNT_W'(1);
  assign val_left_dec = val_left - 4'd1;
  assign len_left_dec = len_left - 2'd1;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      accum_or[8*i +: 8] = (val_shift == 3'(i)) ? (value_accum[8*i +: 8] | b)
                                                 : value_accum[8*i +: 8];
    end
  end

  // next state
  always_comb begin
    phase_next         = phase;
    len_left_next      = len_left;
    target_count_next  = target_count;
    decoded_count_next = decoded_count;
    val_left_next      = val_left;
    val_shift_next     = val_shift;
    value_accum_next   = value_accum;
    recent_bytes_next  = {recent_bytes[31:0], b};
    elem_emit          = 1'b0;
    elem_val           = '0;
    done_sum           = 1'b0;
    case (phase)
      anpe_pkg::PH_SCAN: begin
        if (b == anpe_pkg::OP_PACKAGE && recent_bytes == hdr) begin
          phase_next         = anpe_pkg::PH_PKG0;
          decoded_count_next = '0;
          target_count_next  = '0;
        end
      end
      anpe_pkg::PH_PKG0: begin
        len_left_next = b[7:6];
        phase_next    = (b[7:6] != 2'd0) ? anpe_pkg::PH_PKGN : anpe_pkg::PH_COUNT;
      end
      anpe_pkg::PH_PKGN: begin
        len_left_next = len_left_dec;
        if (len_left_dec == 2'd0) begin
          phase_next = anpe_pkg::PH_COUNT;
        end
      end
      anpe_pkg::PH_COUNT: begin
        target_count_next  = clamp;
        decoded_count_next = '0;
        if (clamp == '0) begin
          done_sum   = 1'b1;
          phase_next = anpe_pkg::PH_DONE;
        end else begin
          phase_next = anpe_pkg::PH_OP;
        end
      end
      anpe_pkg::PH_OP: begin
        value_accum_next = '0;
        val_shift_next   = '0;
        if (b == anpe_pkg::OP_ZERO || b == anpe_pkg::OP_ONE) begin
          elem_emit = 1'b1;
          elem_val  = {56'd0, b};
        end else if (b == anpe_pkg::OP_BYTE) begin
          val_left_next = 4'd1;
          phase_next    = anpe_pkg::PH_DATA;
        end else if (b == anpe_pkg::OP_WORD) begin
          val_left_next = 4'd2;
          phase_next    = anpe_pkg::PH_DATA;
        end else if (b == anpe_pkg::OP_DWORD) begin
          val_left_next = 4'd4;
          phase_next    = anpe_pkg::PH_DATA;
        end else if (b == anpe_pkg::OP_QWORD) begin
          val_left_next = 4'd8;
          phase_next    = anpe_pkg::PH_DATA;
        end else begin
          done_sum   = 1'b1;
          phase_next = anpe_pkg::PH_DONE;
        end
      end
      anpe_pkg::PH_DATA: begin
        value_accum_next = accum_or;
        val_shift_next   = val_shift + 3'd1;
        val_left_next    = val_left_dec;
        if (val_left_dec == 4'd0) begin
          phase_next = anpe_pkg::PH_OP;
          elem_emit  = 1'b1;
          elem_val   = accum_or;
        end
      end
      default: begin
      end
    endcase
    // element completion and count check
    if (elem_emit) begin
      decoded_count_next = dec_inc;
      if (dec_inc >= target_count) begin
        done_sum   = 1'b1;
        phase_next = anpe_pkg::PH_DONE;
      end
    end
  end

  // results of this byte
  always_comb begin
    last_sum = s_tlast && phase != anpe_pkg::PH_DONE && phase_next != anpe_pkg::PH_DONE;
    sum_any  = done_sum || last_sum;

    elem_res            = '0;
    elem_res.elem_value = elem_val;
    elem_res.elem_index = IDX_W'(decoded_count);

    sum_res            = '0;
    sum_res.is_summary = 1'b1;
    sum_res.elem_count = OCW'(decoded_count_next);
    sum_res.found      = (decoded_count_next != '0);

    r0    = '0;
    r1    = '0;
    n_res = 2'd0;
    if (elem_emit) begin
      r0 = elem_res;
      if (sum_any) begin
        r1    = sum_res;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (sum_any) begin
      r0    = sum_res;
      n_res = 2'd1;
    end
    if (n_res == 2'd1) begin
      r0.run_end = 1'b1;
    end
    if (n_res == 2'd2) begin
      r1.run_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_code <= anpe_pkg::NAME_CODE_RESET;
    end else if (cfg_we) begin
      name_code <= cfg_wdata;
    end
  end

  // parser registers; end of stream returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (in_acc && s_tlast)) begin
      phase         <= anpe_pkg::PH_SCAN;
      recent_bytes  <= '0;
      len_left      <= '0;
      target_count  <= '0;
      decoded_count <= '0;
      val_left      <= '0;
      val_shift     <= '0;
      value_accum   <= '0;
    end else if (in_acc) begin
      phase         <= phase_next;
      recent_bytes  <= recent_bytes_next;
      len_left      <= len_left_next;
      target_count  <= target_count_next;
      decoded_count <= decoded_count_next;
      val_left      <= val_left_next;
      val_shift     <= val_shift_next;
      value_accum   <= value_accum_next;
    end
  end

  // output queue: a new byte is only taken when the queue is empty or drains this cycle
  assign s_tready = (q_count == 2'd0) || (q_count == 2'd1 && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= 2'd0;
    end else if (in_acc) begin
      q_count <= n_res;
    end else if (out_acc) begin
      q_count <= q_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q0 <= r0;
      q1 <= r1;
    end else if (out_acc) begin
      q0 <= q1;
    end
  end

  assign m_tvalid = (q_count != 2'd0);
  assign m_tdata  = {6'd0, q0.found, q0.elem_count, q0.elem_index, q0.elem_value};
  assign m_tuser  = q0.is_summary;
  assign m_tlast  = q0.run_end;

  `ANPE_ASSERT_IMP(a_q_depth, 1'b1, q_count != 2'd3, "output queue overfilled")
  `ANPE_ASSERT_IMP(a_elem_in_range,
    phase == anpe_pkg::PH_OP || phase == anpe_pkg::PH_DATA,
    decoded_count < target_count, "element count passed target while parsing")
  `ANPE_ASSERT_NXT(a_stream_end_clears, in_acc && s_tlast,
    phase == anpe_pkg::PH_SCAN && decoded_count == '0 && recent_bytes == '0,
    "state not cleared at stream end")
  `ANPE_ASSERT_IMP(a_summary_clean, m_tvalid && m_tuser,
    m_tdata[63:0] == 64'd0 && m_tdata[67:64] == 4'd0, "summary carries element data")
  `ANPE_ASSERT_IMP(a_elem_clean, m_tvalid && !m_tuser,
    m_tdata[73:68] == 6'd0, "element result carries summary data")

endmodule

`default_nettype wire
